/* rtl/asm_pkg.sv */
package asm_pkg;

  // Frame length and segment padding in centiseconds
  localparam logic [31:0] FRAME_CS = 32'd3;
  localparam logic [31:0] PAD_CS   = 32'd1;

  // Register indexes on the configuration channel
  localparam logic [1:0] REG_INVERT_SENSE = 2'd0;
  localparam logic [1:0] REG_MIN_GAP      = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH   = 2'd2;

  // Register values after reset
  localparam logic [15:0] MIN_GAP_RESET    = 16'd20;
  localparam logic [15:0] MIN_LENGTH_RESET = 16'd20;

  // Result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        invert_sense;
    logic [15:0] min_gap;
    logic [15:0] min_length;
  } asm_cfg_t;

  typedef struct packed {
    logic        run_open;
    logic [31:0] run_begin;
    logic [31:0] time_now;
    logic        pend_valid;
    logic [31:0] pend_start;
    logic [31:0] pend_end;
    logic [31:0] kept_sum;
  } asm_state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] total_time;
    logic [31:0] total_kept;
  } asm_res_t;

  // Add with saturation at all ones
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

/* rtl/activity_segment_merger.sv */
// The first result of a word passes the input register and then the result register
// before it reaches the output; a full result group holds the word in the input register.
// One word per cycle while each word gives at most one result and m_tready is high; a word
// with k results holds the result register until all k are taken (k is at most 3).
// Reset (rst, synchronous): clears stream state and handshakes, and sets the
// registers to invert_sense 0, min_gap 20, min_length 20.
module activity_segment_merger import asm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [0] voice, [7:1] zero
  input  logic         s_tlast,   // final_frame
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // seg_start, seg_end, total_time, total_kept
  output logic         m_tuser,   // kind
  output logic         m_tlast,   // last_of_run
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  asm_cfg_t   cfg;
  asm_state_t st;
  asm_state_t st_next;
  asm_res_t   step_res [3];
  logic [2:0] step_valid;

  logic       in_valid;
  logic       in_voice;
  logic       in_fin;

  asm_res_t   grp [3];
  logic [2:0] grp_valid;
  logic [2:0] grp_valid_pop;
  logic       single;
  logic       pop;
  logic       grp_free;
  logic       move;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_sense <= 1'b0;
      cfg.min_gap      <= MIN_GAP_RESET;
      cfg.min_length   <= MIN_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INVERT_SENSE: cfg.invert_sense <= cfg_data[0];
        REG_MIN_GAP:      cfg.min_gap      <= cfg_data;
        REG_MIN_LENGTH:   cfg.min_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result group handshake
  assign single   = (grp_valid == 3'b001) || (grp_valid == 3'b010) ||
                    (grp_valid == 3'b100);
  assign m_tvalid = |grp_valid;
  assign pop      = m_tvalid && m_tready;
  assign grp_free = !m_tvalid || (pop && single);
  assign move     = in_valid && grp_free;
  assign s_tready = !in_valid || grp_free;

  // Drop the first valid result on a pop
  always_comb begin
    grp_valid_pop = grp_valid;
    if (grp_valid[0])      grp_valid_pop[0] = 1'b0;
    else if (grp_valid[1]) grp_valid_pop[1] = 1'b0;
    else                   grp_valid_pop[2] = 1'b0;
  end

  // Show the first valid result
  always_comb begin
    asm_res_t r;
    if (grp_valid[0])      r = grp[0];
    else if (grp_valid[1]) r = grp[1];
    else                   r = grp[2];
    m_tdata = {r.total_kept, r.total_time, r.seg_end, r.seg_start};
    m_tuser = r.kind;
    m_tlast = single;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_voice <= s_tdata[0];
      in_fin   <= s_tlast;
    end
  end

  asm_step u_step (
    .cfg       (cfg),
    .cur       (st),
    .voice     (in_voice),
    .fin       (in_fin),
    .nxt       (st_next),
    .res       (step_res),
    .res_valid (step_valid)
  );

  // Stream state and result group
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      grp_valid <= '0;
    end else if (move) begin
      st        <= st_next;
      grp_valid <= step_valid;
    end else if (pop) begin
      grp_valid <= grp_valid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      grp <= step_res;
    end
  end

endmodule

/* rtl/asm_step.sv */
module asm_step import asm_pkg::*; (
  input  asm_cfg_t   cfg,
  input  asm_state_t cur,
  input  logic       voice,
  input  logic       fin,
  output asm_state_t nxt,
  output asm_res_t   res [3],
  output logic [2:0] res_valid
);

  logic        active;
  logic [31:0] t;
  logic [31:0] tn;
  logic        close_a;
  logic        close_b;
  logic        do_close;
  logic [31:0] beg_c;
  logic [31:0] end_c;
  logic [31:0] s_c;
  logic [31:0] e_c;
  logic        merge;
  logic [31:0] len1;
  logic        keep1;
  logic [31:0] kept1;
  logic        pv1;
  logic [31:0] ps1;
  logic [31:0] pe1;
  logic [31:0] len2;
  logic        keep2;
  logic [31:0] kept2;

  always_comb begin
    t      = cur.time_now;
    tn     = sat_add(t, FRAME_CS);
    active = voice ^ cfg.invert_sense;

    // A run closes on an inactive frame, or at the final frame while active
    close_a  = !active && cur.run_open;
    close_b  = fin && active;
    do_close = close_a || close_b;
    beg_c    = (active && !cur.run_open) ? t : cur.run_begin;
    end_c    = close_b ? tn : t;
    s_c      = (beg_c >= PAD_CS) ? beg_c - PAD_CS : 32'd0;
    e_c      = sat_add(end_c, PAD_CS);
    merge    = cur.pend_valid &&
               ({1'b0, s_c} < ({1'b0, cur.pend_end} + {17'd0, cfg.min_gap}));

    // Release the pending segment when the new one does not merge
    len1  = (cur.pend_end >= cur.pend_start) ? cur.pend_end - cur.pend_start : 32'd0;
    keep1 = do_close && !merge && cur.pend_valid && (len1 >= {16'd0, cfg.min_length});
    kept1 = keep1 ? sat_add(cur.kept_sum, len1) : cur.kept_sum;

    // Pending segment after the close
    pv1 = cur.pend_valid;
    ps1 = cur.pend_start;
    pe1 = cur.pend_end;
    if (do_close) begin
      if (merge) begin
        if (e_c > cur.pend_end) pe1 = e_c;
      end else begin
        pv1 = 1'b1;
        ps1 = s_c;
        pe1 = e_c;
      end
    end

    // Flush the pending segment at the final frame
    len2  = (pe1 >= ps1) ? pe1 - ps1 : 32'd0;
    keep2 = fin && pv1 && (len2 >= {16'd0, cfg.min_length});
    kept2 = keep2 ? sat_add(kept1, len2) : kept1;

    res[0] = '{kind: KIND_SEGMENT, seg_start: cur.pend_start, seg_end: cur.pend_end,
               total_time: tn, total_kept: kept1};
    res[1] = '{kind: KIND_SEGMENT, seg_start: ps1, seg_end: pe1,
               total_time: tn, total_kept: kept2};
    res[2] = '{kind: KIND_SUMMARY, seg_start: 32'd0, seg_end: 32'd0,
               total_time: tn, total_kept: kept2};
    res_valid = {fin, keep2, keep1};

    // Advance the stream state, or clear it after the summary
    if (fin) begin
      nxt = '0;
    end else begin
      nxt.run_open   = active;
      nxt.run_begin  = beg_c;
      nxt.time_now   = tn;
      nxt.pend_valid = pv1;
      nxt.pend_start = ps1;
      nxt.pend_end   = pe1;
      nxt.kept_sum   = kept1;
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import asm_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = 8;
  localparam int          PHASE_ITEMS = 21;
  localparam int          PLAN_LEN    = 27;
  localparam int          PHASES      = 6;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [31:0] SAT_MAX     = 32'hFFFF_FFFF;

  // One result word as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] total_time;
    logic [31:0] total_kept;
    logic        tail;
  } seg_word_t;

  // One directed frame, with a typed-in result where it is obvious
  typedef struct packed {
    logic      voice;
    logic      fin;
    logic      typed;
    seg_word_t word;
  } frame_row_t;

  localparam seg_word_t NO_WORD = '0;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;   // [0] voice, [7:1] zero
  logic         s_tlast;   // final_frame
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;   // seg_start, seg_end, total_time, total_kept
  logic         m_tuser;   // kind
  logic         m_tlast;   // last_of_run
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  activity_segment_merger i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy and stream state of the segment predictor
  logic        sense_inv;
  logic [15:0] merge_gap;
  logic [15:0] keep_len;
  logic        run_active;
  logic [31:0] run_from;
  logic [31:0] clock_cs;
  logic        pend_held;
  logic [31:0] pend_lo;
  logic [31:0] pend_hi;
  logic [31:0] kept_cs;

  seg_word_t   frame_words[$];
  seg_word_t   segments_due[$];
  int          errors;
  int          cycles;
  int          stall_left;
  logic        calm;
  frame_row_t  plan[PLAN_LEN];
  asm_cfg_t    phase_cfg[PHASES];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    if (a > SAT_MAX - b)
      return SAT_MAX;
    return a + b;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm)
      return 0;
    if (r < 12)
      return 0;
    if (r < 18)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Append one word to the expected results of the current frame
  task automatic add_frame_word(input seg_word_t w);
    frame_words.insert(frame_words.size(), w);
  endtask

  // Append one word to the results still owed by the block
  task automatic add_due_word(input seg_word_t w);
    segments_due.insert(segments_due.size(), w);
  endtask

  task automatic emit_word(input logic kind, input logic [31:0] lo, input logic [31:0] hi);
    seg_word_t w;
    w = '{kind, lo, hi, clock_cs, kept_cs, 1'b0};
    add_frame_word(w);
  endtask

  // Release the pending segment: keep it if long enough, else drop it
  task automatic flush_pending();
    logic [31:0] len;
    if (pend_held) begin
      len = (pend_hi >= pend_lo) ? pend_hi - pend_lo : 32'd0;
      if (len >= {16'd0, keep_len}) begin
        kept_cs = add_sat(kept_cs, len);
        emit_word(KIND_SEGMENT, pend_lo, pend_hi);
      end
    end
    pend_held = 1'b0;
  endtask

  // Close the open run, pad it, and merge it into or replace the pending one
  task automatic close_segment(input logic [31:0] end_cs);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (run_from >= PAD_CS) ? run_from - PAD_CS : 32'd0;
    hi = add_sat(end_cs, PAD_CS);
    run_active = 1'b0;
    if (pend_held && ({1'b0, lo} < {1'b0, pend_hi} + {17'd0, merge_gap})) begin
      if (hi > pend_hi)
        pend_hi = hi;
    end else begin
      flush_pending();
      pend_held = 1'b1;
      pend_lo   = lo;
      pend_hi   = hi;
    end
  endtask

  task automatic clear_stream();
    run_active = 1'b0;
    run_from   = '0;
    clock_cs   = '0;
    pend_held  = 1'b0;
    pend_lo    = '0;
    pend_hi    = '0;
    kept_cs    = '0;
  endtask

  // Advance the predictor by one frame; results land in frame_words
  task automatic advance_stream(input logic voice, input logic fin);
    logic [31:0] t;
    frame_words.delete();
    t = clock_cs;
    clock_cs = add_sat(t, FRAME_CS);
    if (voice ^ sense_inv) begin
      if (!run_active) begin
        run_active = 1'b1;
        run_from   = t;
      end
    end else if (run_active) begin
      close_segment(t);
    end
    if (fin) begin
      if (run_active)
        close_segment(clock_cs);
      flush_pending();
      emit_word(KIND_SUMMARY, '0, '0);
    end
    if (frame_words.size() != 0)
      frame_words[frame_words.size() - 1].tail = 1'b1;
    if (fin)
      clear_stream();
  endtask

  task automatic note_error(input string msg);
    errors = errors + 1;
    if (errors <= 10)
      $display("%s", msg);
  endtask

  // Send one frame word and queue what it should produce
  task automatic send_frame(input logic voice, input logic fin, input logic typed,
                            input seg_word_t word);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, voice};
    s_tlast  = fin;
    do @(posedge clk); while (!s_tready);
    advance_stream(voice, fin);
    if (typed)
      add_due_word(word);
    else
      foreach (frame_words[i]) add_due_word(frame_words[i]);
    @(negedge clk);
  endtask

  // Hold until every queued result has arrived, then let the pipe settle
  task automatic drain();
    s_tvalid = 1'b0;
    while (segments_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_INVERT_SENSE: sense_inv = data[0];
      REG_MIN_GAP:      merge_gap = data;
      REG_MIN_LENGTH:   keep_len  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result sink: random back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready   = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    seg_word_t got;
    seg_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
              m_tlast};
      if (segments_due.size() == 0) begin
        note_error($sformatf("unexpected word: kind %0d start %0d end %0d time %0d kept %0d last %0d",
                             got.kind, got.seg_start, got.seg_end, got.total_time,
                             got.total_kept, got.tail));
      end else begin
        want = segments_due.pop_front();
        if (got !== want)
          note_error($sformatf({"mismatch: want kind %0d start %0d end %0d time %0d kept %0d ",
                                "last %0d, got kind %0d start %0d end %0d time %0d kept %0d ",
                                "last %0d"},
                               want.kind, want.seg_start, want.seg_end, want.total_time,
                               want.total_kept, want.tail, got.kind, got.seg_start,
                               got.seg_end, got.total_time, got.total_kept, got.tail));
      end
    end
  end

  // Stimulus
  initial begin
    logic cur_voice;
    logic fin;
    int   r;

    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    calm       = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_INVERT_SENSE;
    cfg_data   = '0;
    sense_inv  = 1'b0;
    merge_gap  = MIN_GAP_RESET;
    keep_len   = MIN_LENGTH_RESET;
    clear_stream();

    // Directed frames under the reset register values (times in cs)
    plan = '{
      // empty stream: summary only
      '{1'b0, 1'b1, 1'b1, '{KIND_SUMMARY, 32'd0, 32'd0, 32'd3, 32'd0, 1'b1}},
      // one-frame run at time zero, padded to [0,4], too short to keep
      '{1'b1, 1'b1, 1'b1, '{KIND_SUMMARY, 32'd0, 32'd0, 32'd3, 32'd0, 1'b1}},
      // run from 0 to 18 gives [0,19]
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b0, 1'b0, NO_WORD},
      // short run one frame later merges into [0,25]
      '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b0, 1'b0, NO_WORD}, '{1'b0, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b0, 1'b0, NO_WORD}, '{1'b0, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b0, 1'b0, NO_WORD}, '{1'b0, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b0, 1'b0, NO_WORD}, '{1'b0, 1'b0, 1'b0, NO_WORD},
      // far run releases [0,25]; final frame drops the short one
      '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b0, 1'b1, 1'b0, NO_WORD},
      // run still open at the final frame is padded like the others
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b1, 1'b0, 1'b0, NO_WORD}, '{1'b1, 1'b0, 1'b0, NO_WORD},
      '{1'b1, 1'b1, 1'b0, NO_WORD}
    };

    // Register settings per random phase; the last one is drawn at random
    phase_cfg[0] = '{1'b1, 16'd0,     16'd0};
    phase_cfg[1] = '{1'b0, 16'hFFFF,  16'hFFFF};
    phase_cfg[2] = '{1'b1, 16'd2,     16'd6};
    phase_cfg[3] = '{1'b0, 16'd0,     16'hFFFF};
    phase_cfg[4] = '{1'b0, 16'd20,    16'd20};
    phase_cfg[5] = '{1'($urandom_range(0, 1)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40))};

    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part
    for (int i = 0; i < PLAN_LEN; i++)
      send_frame(plan[i].voice, plan[i].fin, plan[i].typed, plan[i].word);

    // Random part: bursty voice with random content, some noise, random stream ends
    cur_voice = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm = (p == 2);
      if (p % 2 == 1)
        write_reg(REG_UNUSED, 16'($urandom));
      write_reg(REG_MIN_LENGTH, phase_cfg[p].min_length);
      write_reg(REG_INVERT_SENSE, {15'($urandom), phase_cfg[p].invert_sense});
      write_reg(REG_MIN_GAP, phase_cfg[p].min_gap);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 9);
        if (r < 3)
          cur_voice = ~cur_voice;
        else if (r == 9)
          cur_voice = 1'($urandom_range(0, 1));
        fin = ($urandom_range(0, 13) == 0);
        // hold the sender now and then until everything is out
        if ($urandom_range(0, 29) == 0)
          drain();
        send_frame(cur_voice, fin, 1'b0, NO_WORD);
      end
    end

    drain();
    if (errors == 0 && segments_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/asm_pkg.sv
rtl/asm_step.sv
rtl/activity_segment_merger.sv
sim/tb_top.sv
